/* rtl/sit_pkg.sv */
// Shared constants and types for the segment intersection test.
package sit_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int TOL_BITS = 20;

	typedef enum logic {
		OP_OPEN   = 1'b0,
		OP_CLOSED = 1'b1
	} op_t;
endpackage

/* rtl/sit_if.sv */
// Valid/ready channels for segment requests, results and the tolerance register.
interface sit_seg_if #(parameter int COORD_BITS = 16);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] a_start_x;
	logic signed [COORD_BITS-1:0] a_start_y;
	logic signed [COORD_BITS-1:0] a_end_x;
	logic signed [COORD_BITS-1:0] a_end_y;
	logic signed [COORD_BITS-1:0] b_start_x;
	logic signed [COORD_BITS-1:0] b_start_y;
	logic signed [COORD_BITS-1:0] b_end_x;
	logic signed [COORD_BITS-1:0] b_end_y;
	logic opcode;
	modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, opcode, input ready);
	modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, opcode, output ready);
endinterface

interface sit_res_if #(parameter int COORD_BITS = 16);
	logic valid;
	logic ready;
	logic hit;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	modport source (output valid, hit, point_x, point_y, input ready);
	modport sink (input valid, hit, point_x, point_y, output ready);
endinterface

interface sit_cfg_if;
	import sit_pkg::*;
	logic valid;
	logic ready;
	logic [TOL_BITS-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/sit_div_pipe.sv */
// Pipelined restoring divider giving a saturation flag and a truncated quotient per axis.
module sit_div_pipe import sit_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int NW = 3 * COORD_BITS + 8,
	parameter int SIDE_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [NW-1:0] num_x,
	input  logic [NW-1:0] num_y,
	input  logic [NW-1:0] den,
	input  logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic [COORD_BITS-1:0] quo_x,
	output logic [COORD_BITS-1:0] quo_y,
	output logic ovf_x,
	output logic ovf_y,
	output logic [SIDE_W-1:0] side_out
);
	localparam int W = COORD_BITS;

	logic          v_s [W+1];
	logic [NW-1:0] rx_s [W+1];
	logic [NW-1:0] ry_s [W+1];
	logic [NW-1:0] d_s [W+1];
	logic [W-1:0]  qx_s [W+1];
	logic [W-1:0]  qy_s [W+1];
	logic          ox_s [W+1];
	logic          oy_s [W+1];
	logic [SIDE_W-1:0] sd_s [W+1];

	logic [NW-1:0] dsh;
	assign dsh = den << W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0] <= num_x;
			ry_s[0] <= num_y;
			d_s[0]  <= den;
			qx_s[0] <= '0;
			qy_s[0] <= '0;
			ox_s[0] <= num_x >= dsh;
			oy_s[0] <= num_y >= dsh;
			sd_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= W; k++) begin : g_stage
		localparam int BIT = W - k;
		logic [NW-1:0] dk;
		logic gx, gy;
		assign dk = d_s[k-1] << BIT;
		assign gx = rx_s[k-1] >= dk;
		assign gy = ry_s[k-1] >= dk;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k] <= gx ? rx_s[k-1] - dk : rx_s[k-1];
				ry_s[k] <= gy ? ry_s[k-1] - dk : ry_s[k-1];
				qx_s[k] <= qx_s[k-1] | (W'(gx) << BIT);
				qy_s[k] <= qy_s[k-1] | (W'(gy) << BIT);
				d_s[k]  <= d_s[k-1];
				ox_s[k] <= ox_s[k-1];
				oy_s[k] <= oy_s[k-1];
				sd_s[k] <= sd_s[k-1];
			end
		end
	end

	assign out_valid = v_s[W];
	assign quo_x = qx_s[W];
	assign quo_y = qy_s[W];
	assign ovf_x = ox_s[W];
	assign ovf_y = oy_s[W];
	assign side_out = sd_s[W];
endmodule

/* rtl/segment_intersection_test.sv */
// Top level of the pipelined segment intersection test.
// Throughput: one request per cycle; the whole pipeline holds while the result is not taken.
// The quotient is resolved one bit per stage, which sets the depth.
// Reset clears all valid bits and the tolerance register to zero.
module segment_intersection_test import sit_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	sit_seg_if.sink seg_in,
	sit_res_if.source seg_out,
	sit_cfg_if.sink cfg
);
	localparam int W  = COORD_BITS;
	localparam int DW = W + 1;
	localparam int PW = 2 * W + 2;
	localparam int CW = 2 * W + 6;
	localparam int NW = 3 * W + 8;
	localparam int SIDE_W = 4 + 2 * W;

	logic [TOL_BITS-1:0] tol_q;
	logic en;
	logic out_valid_q;

	assign en = !out_valid_q || seg_out.ready;
	assign seg_in.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg.valid) begin
			tol_q <= cfg.data;
		end
	end

	// Stage 1: differences.
	logic v_s1, op_s1;
	logic signed [W-1:0] ax_s1, ay_s1, cx_s1, cy_s1, ex_s1, ey_s1;
	logic signed [DW-1:0] d1x_s1, d1y_s1, d2x_s1, d2y_s1, xx_s1, xy_s1, fx_s1, fy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= seg_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= seg_in.opcode;
			ax_s1  <= seg_in.a_start_x;
			ay_s1  <= seg_in.a_start_y;
			cx_s1  <= seg_in.b_start_x;
			cy_s1  <= seg_in.b_start_y;
			ex_s1  <= seg_in.b_end_x;
			ey_s1  <= seg_in.b_end_y;
			d1x_s1 <= DW'(seg_in.a_end_x) - DW'(seg_in.a_start_x);
			d1y_s1 <= DW'(seg_in.a_end_y) - DW'(seg_in.a_start_y);
			d2x_s1 <= DW'(seg_in.b_end_x) - DW'(seg_in.b_start_x);
			d2y_s1 <= DW'(seg_in.b_end_y) - DW'(seg_in.b_start_y);
			xx_s1  <= DW'(seg_in.b_start_x) - DW'(seg_in.a_start_x);
			xy_s1  <= DW'(seg_in.b_start_y) - DW'(seg_in.a_start_y);
			fx_s1  <= DW'(seg_in.b_end_x) - DW'(seg_in.a_start_x);
			fy_s1  <= DW'(seg_in.b_end_y) - DW'(seg_in.a_start_y);
		end
	end

	// Stage 2: products.
	logic v_s2, op_s2;
	logic signed [W-1:0] ax_s2, ay_s2, cx_s2, cy_s2, ex_s2, ey_s2;
	logic signed [DW-1:0] d1x_s2, d1y_s2;
	logic signed [PW-1:0] m_n1a_s2, m_n1b_s2, m_n2a_s2, m_n2b_s2, m_da_s2, m_db_s2;
	logic signed [PW-1:0] m_p1a_s2, m_p1b_s2, m_p2a_s2, m_p2b_s2, m_la_s2, m_lb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= op_s1;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			ex_s2 <= ex_s1;
			ey_s2 <= ey_s1;
			d1x_s2 <= d1x_s1;
			d1y_s2 <= d1y_s1;
			m_n1a_s2 <= PW'(xx_s1) * PW'(d2y_s1);
			m_n1b_s2 <= PW'(xy_s1) * PW'(d2x_s1);
			m_n2a_s2 <= PW'(xx_s1) * PW'(d1y_s1);
			m_n2b_s2 <= PW'(xy_s1) * PW'(d1x_s1);
			m_da_s2  <= PW'(d1x_s1) * PW'(d2y_s1);
			m_db_s2  <= PW'(d1y_s1) * PW'(d2x_s1);
			m_p1a_s2 <= PW'(xx_s1) * PW'(d1x_s1);
			m_p1b_s2 <= PW'(xy_s1) * PW'(d1y_s1);
			m_p2a_s2 <= PW'(fx_s1) * PW'(d1x_s1);
			m_p2b_s2 <= PW'(fy_s1) * PW'(d1y_s1);
			m_la_s2  <= PW'(d1x_s1) * PW'(d1x_s1);
			m_lb_s2  <= PW'(d1y_s1) * PW'(d1y_s1);
		end
	end

	// Stage 3: cross and dot products.
	logic v_s3, op_s3;
	logic signed [W-1:0] ax_s3, ay_s3, cx_s3, cy_s3, ex_s3, ey_s3;
	logic signed [DW-1:0] d1x_s3, d1y_s3;
	logic signed [CW-1:0] n1_s3, n2_s3, d_s3, p1_s3, p2_s3, len_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3 <= op_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
			ex_s3 <= ex_s2;
			ey_s3 <= ey_s2;
			d1x_s3 <= d1x_s2;
			d1y_s3 <= d1y_s2;
			n1_s3  <= CW'(m_n1a_s2) - CW'(m_n1b_s2);
			n2_s3  <= CW'(m_n2a_s2) - CW'(m_n2b_s2);
			d_s3   <= CW'(m_da_s2) - CW'(m_db_s2);
			p1_s3  <= CW'(m_p1a_s2) + CW'(m_p1b_s2);
			p2_s3  <= CW'(m_p2a_s2) + CW'(m_p2b_s2);
			len_s3 <= CW'(m_la_s2) + CW'(m_lb_s2);
		end
	end

	// Stage 4: tolerant decisions and numerator products.
	logic signed [CW-1:0] t_c, nt_c;
	assign t_c  = CW'($signed({1'b0, tol_q}));
	assign nt_c = -t_c;

	logic signed [CW-1:0] dn_c, n1n_c, n2n_c, lo_c, hi_c;
	logic in1c, in1o, in2c, in2o, deq0, n1eq0, pick_start;
	logic hit_np, hit_par;

	always_comb begin
		deq0  = (d_s3 >= nt_c) && (d_s3 <= t_c);
		n1eq0 = (n1_s3 >= nt_c) && (n1_s3 <= t_c);
		dn_c  = d_s3[CW-1] ? -d_s3 : d_s3;
		n1n_c = d_s3[CW-1] ? -n1_s3 : n1_s3;
		n2n_c = d_s3[CW-1] ? -n2_s3 : n2_s3;
		in1c  = (n1n_c >= nt_c) && (n1n_c <= dn_c + t_c);
		in1o  = (n1n_c > t_c) && (n1n_c < dn_c - t_c);
		in2c  = (n2n_c >= nt_c) && (n2n_c <= dn_c + t_c);
		in2o  = (n2n_c > t_c) && (n2n_c < dn_c - t_c);
		if (op_s3 == OP_CLOSED) begin
			hit_np = in1c && in2c;
		end else begin
			hit_np = (in1o && in2c) || (in1c && in2o);
		end
		pick_start = (p1_s3 > nt_c) && (p1_s3 < len_s3 + t_c);
		lo_c = (p2_s3 < p1_s3) ? p2_s3 : p1_s3;
		hi_c = (p2_s3 < p1_s3) ? p1_s3 : p2_s3;
		if (!n1eq0) begin
			hit_par = 1'b0;
		end else if (op_s3 == OP_CLOSED) begin
			hit_par = (hi_c >= nt_c) && (lo_c <= len_s3 + t_c);
		end else begin
			hit_par = (hi_c > t_c) && (lo_c < len_s3 - t_c);
		end
	end

	logic v_s4, hit_s4, par_s4;
	logic signed [W-1:0] ppx_s4, ppy_s4;
	logic signed [NW-1:0] mxa_s4, mxb_s4, mya_s4, myb_s4;
	logic signed [CW-1:0] d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			par_s4 <= deq0;
			hit_s4 <= deq0 ? hit_par : hit_np;
			ppx_s4 <= pick_start ? cx_s3 : ex_s3;
			ppy_s4 <= pick_start ? cy_s3 : ey_s3;
			d_s4   <= d_s3;
			mxa_s4 <= NW'(ax_s3) * NW'(d_s3);
			mxb_s4 <= NW'(n1_s3) * NW'(d1x_s3);
			mya_s4 <= NW'(ay_s3) * NW'(d_s3);
			myb_s4 <= NW'(n1_s3) * NW'(d1y_s3);
		end
	end

	// Stage 5: numerators, signs and magnitudes.
	logic signed [NW-1:0] numx_c, numy_c;
	assign numx_c = mxa_s4 + mxb_s4;
	assign numy_c = mya_s4 + myb_s4;

	logic v_s5;
	logic [NW-1:0] ax_mag_s5, ay_mag_s5, d_mag_s5;
	logic [SIDE_W-1:0] side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_mag_s5 <= numx_c[NW-1] ? NW'(-numx_c) : NW'(numx_c);
			ay_mag_s5 <= numy_c[NW-1] ? NW'(-numy_c) : NW'(numy_c);
			d_mag_s5  <= d_s4[CW-1] ? NW'(-d_s4) : NW'(d_s4);
			side_s5   <= {hit_s4, par_s4, numx_c[NW-1] ^ d_s4[CW-1],
				numy_c[NW-1] ^ d_s4[CW-1], ppx_s4, ppy_s4};
		end
	end

	logic dv_valid, ovfx, ovfy;
	logic [W-1:0] qx, qy;
	logic [SIDE_W-1:0] side_d;

	sit_div_pipe #(
		.COORD_BITS(W),
		.NW(NW),
		.SIDE_W(SIDE_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s5),
		.num_x(ax_mag_s5),
		.num_y(ay_mag_s5),
		.den(d_mag_s5),
		.side_in(side_s5),
		.out_valid(dv_valid),
		.quo_x(qx),
		.quo_y(qy),
		.ovf_x(ovfx),
		.ovf_y(ovfy),
		.side_out(side_d)
	);

	// Output stage: saturation and selection.
	localparam logic [W-1:0] HALF = W'(1) << (W - 1);
	localparam logic [W-1:0] MAXV = HALF - W'(1);

	logic f_hit, f_par, f_negx, f_negy;
	logic [W-1:0] f_ppx, f_ppy, satx, saty;
	assign {f_hit, f_par, f_negx, f_negy, f_ppx, f_ppy} = side_d;

	always_comb begin
		if (f_negx) begin
			satx = (ovfx || qx > HALF) ? HALF : -qx;
		end else begin
			satx = (ovfx || qx > MAXV) ? MAXV : qx;
		end
		if (f_negy) begin
			saty = (ovfy || qy > HALF) ? HALF : -qy;
		end else begin
			saty = (ovfy || qy > MAXV) ? MAXV : qy;
		end
	end

	logic hit_q;
	logic [W-1:0] px_q, py_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= f_hit;
			px_q  <= !f_hit ? '0 : (f_par ? f_ppx : satx);
			py_q  <= !f_hit ? '0 : (f_par ? f_ppy : saty);
		end
	end

	assign seg_out.valid   = out_valid_q;
	assign seg_out.hit     = hit_q;
	assign seg_out.point_x = px_q;
	assign seg_out.point_y = py_q;
endmodule

/* sim/testbench.sv */
// Self-checking testbench for the segment intersection test: directed table, then random pairs.
`timescale 1ns / 1ps
module testbench;
	import sit_pkg::*;

	localparam int CB = 16;
	localparam int LATENCY = CB + 7;

	typedef struct {
		logic signed [CB-1:0] c[8];
		op_t op;
		bit known;
		bit hit;
		logic signed [CB-1:0] px;
		logic signed [CB-1:0] py;
	} seg_row_t;

	typedef struct {
		bit hit;
		logic signed [CB-1:0] px;
		logic signed [CB-1:0] py;
	} meet_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	sit_seg_if #(CB) seg_in();
	sit_res_if #(CB) seg_out();
	sit_cfg_if cfg();

	segment_intersection_test #(.COORD_BITS(CB)) uut (
		.clk(clk), .arst_n(arst_n), .seg_in(seg_in), .seg_out(seg_out), .cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [TOL_BITS-1:0] tol_now = '0;
	meet_t pending[$];
	seg_row_t rows[$];
	int errors = 0;
	bit hold_long = 0;

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	function automatic logic signed [CB-1:0] clamp(input logic signed [127:0] v);
		if (v > 128'sd32767) return 16'sh7fff;
		if (v < -128'sd32768) return 16'sh8000;
		return v[CB-1:0];
	endfunction

	function automatic meet_t predict_meeting(input seg_row_t r);
		logic signed [127:0] t, ax, ay, bx, by, cx, cy, ex, ey;
		logic signed [127:0] d1x, d1y, d2x, d2y, xx, xy, n1, n2, d, p1, p2, len, s;
		bit closed;
		meet_t m;
		t = $signed({108'd0, tol_now});
		ax = r.c[0]; ay = r.c[1]; bx = r.c[2]; by = r.c[3];
		cx = r.c[4]; cy = r.c[5]; ex = r.c[6]; ey = r.c[7];
		closed = (r.op == OP_CLOSED);
		d1x = bx - ax; d1y = by - ay; d2x = ex - cx; d2y = ey - cy;
		xx = cx - ax; xy = cy - ay;
		n1 = xx * d2y - xy * d2x;
		n2 = xx * d1y - xy * d1x;
		d = d1x * d2y - d1y * d2x;
		m.hit = 0; m.px = '0; m.py = '0;
		if (d >= -t && d <= t) begin
			if (n1 >= -t && n1 <= t) begin
				p1 = xx * d1x + xy * d1y;
				p2 = (ex - ax) * d1x + (ey - ay) * d1y;
				len = d1x * d1x + d1y * d1y;
				if (-t < p1 && p1 < len + t) begin
					m.px = cx[CB-1:0]; m.py = cy[CB-1:0];
				end else begin
					m.px = ex[CB-1:0]; m.py = ey[CB-1:0];
				end
				if (p2 < p1) begin
					s = p1; p1 = p2; p2 = s;
				end
				if (closed) m.hit = (p2 >= -t) && (p1 <= len + t);
				else m.hit = (p2 > t) && (p1 < len - t);
			end
		end else begin
			m.px = clamp((ax * d + n1 * d1x) / d);
			m.py = clamp((ay * d + n1 * d1y) / d);
			if (d < 0) begin
				d = -d; n1 = -n1; n2 = -n2;
			end
			if (closed)
				m.hit = n1 >= -t && n1 <= d + t && n2 >= -t && n2 <= d + t;
			else
				m.hit = (n1 > t && n1 < d - t && n2 >= -t && n2 <= d + t)
					|| (n1 >= -t && n1 <= d + t && n2 > t && n2 < d - t);
		end
		if (!m.hit) begin
			m.px = '0; m.py = '0;
		end
		return m;
	endfunction

	function automatic seg_row_t mk(input int v[8], input op_t op);
		seg_row_t r;
		for (int i = 0; i < 8; i++) r.c[i] = CB'(v[i]);
		r.op = op; r.known = 0; r.hit = 0; r.px = '0; r.py = '0;
		return r;
	endfunction

	function automatic seg_row_t mk_known(input int v[8], input op_t op, input bit h,
			input int x, input int y);
		seg_row_t r;
		r = mk(v, op);
		r.known = 1; r.hit = h; r.px = CB'(x); r.py = CB'(y);
		return r;
	endfunction

	function automatic logic signed [CB-1:0] rc(input int span);
		if (span == 0) return CB'($urandom);
		return $signed(CB'($urandom_range(0, 2 * span))) - CB'(span);
	endfunction

	function automatic seg_row_t random_pair();
		seg_row_t r;
		int kind, span;
		int dx, dy, k1, k2;
		kind = $urandom_range(0, 9);
		span = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 400);
		for (int i = 0; i < 8; i++) r.c[i] = rc(span);
		r.op = op_t'($urandom_range(0, 1));
		r.known = 0;
		if (kind < 3) begin
			dx = $urandom_range(0, 40) - 20; dy = $urandom_range(0, 40) - 20;
			k1 = $urandom_range(0, 12) - 4; k2 = $urandom_range(0, 12) - 4;
			r.c[2] = CB'(int'(r.c[0]) + 4 * dx); r.c[3] = CB'(int'(r.c[1]) + 4 * dy);
			r.c[4] = CB'(int'(r.c[0]) + k1 * dx); r.c[5] = CB'(int'(r.c[1]) + k1 * dy);
			r.c[6] = CB'(int'(r.c[0]) + k2 * dx); r.c[7] = CB'(int'(r.c[1]) + k2 * dy);
		end else if (kind < 5) begin
			r.c[4] = ($urandom_range(0, 1)) ? r.c[0] : r.c[2];
			r.c[5] = (r.c[4] == r.c[0]) ? r.c[1] : r.c[3];
		end else if (kind == 5) begin
			r.c[2] = CB'(int'(r.c[0]) + int'($urandom_range(0, 2)) - 1);
			r.c[3] = CB'(int'(r.c[1]) + int'($urandom_range(0, 2)) - 1);
		end
		return r;
	endfunction

	task automatic write_tolerance(input logic [TOL_BITS-1:0] v);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		tol_now = v;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send(input seg_row_t r);
		meet_t m;
		@(negedge clk);
		seg_in.valid <= 1'b1;
		seg_in.a_start_x <= r.c[0]; seg_in.a_start_y <= r.c[1];
		seg_in.a_end_x <= r.c[2]; seg_in.a_end_y <= r.c[3];
		seg_in.b_start_x <= r.c[4]; seg_in.b_start_y <= r.c[5];
		seg_in.b_end_x <= r.c[6]; seg_in.b_end_y <= r.c[7];
		seg_in.opcode <= r.op;
		do @(posedge clk); while (!seg_in.ready);
		m = predict_meeting(r);
		if (r.known && tol_now == '0) begin
			m.hit = r.hit; m.px = r.px; m.py = r.py;
		end
		pending.push_back(m);
	endtask

	task automatic idle_gap();
		int g;
		g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
		if (g != 0) begin
			@(negedge clk);
			seg_in.valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	initial begin
		seg_in.valid = 0; seg_in.opcode = 0;
		seg_in.a_start_x = 0; seg_in.a_start_y = 0; seg_in.a_end_x = 0; seg_in.a_end_y = 0;
		seg_in.b_start_x = 0; seg_in.b_start_y = 0; seg_in.b_end_x = 0; seg_in.b_end_y = 0;
		cfg.valid = 0; cfg.data = 0;
		seg_out.ready = 0;
	end

	always @(negedge clk) begin
		if (hold_long) seg_out.ready <= 1'b0;
		else case ($urandom_range(0, 7))
			0, 1: seg_out.ready <= 1'b0;
			default: seg_out.ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		meet_t w;
		if (arst_n && seg_out.valid && seg_out.ready) begin
			if (pending.size() == 0) begin
				report("unexpected result", seg_out.hit, 0);
			end else begin
				w = pending.pop_front();
				if (seg_out.hit !== w.hit) report("hit", seg_out.hit, w.hit);
				if (seg_out.point_x !== w.px) report("point_x", seg_out.point_x, w.px);
				if (seg_out.point_y !== w.py) report("point_y", seg_out.point_y, w.py);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		int n;
		logic [TOL_BITS-1:0] tols[4];
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Crossing, touching, collinear, degenerate and extreme coordinates.
		rows.push_back(mk_known('{0, 0, 0, 0, 0, 0, 0, 0}, OP_CLOSED, 1, 0, 0));
		rows.push_back(mk_known('{0, 0, 0, 0, 0, 0, 0, 0}, OP_OPEN, 0, 0, 0));
		rows.push_back(mk_known('{-16, 0, 16, 0, 0, -16, 0, 16}, OP_OPEN, 1, 0, 0));
		rows.push_back(mk_known('{0, 0, 32, 0, 32, 0, 32, 32}, OP_CLOSED, 1, 32, 0));
		rows.push_back(mk_known('{0, 0, 32, 0, 32, 0, 32, 32}, OP_OPEN, 0, 0, 0));
		rows.push_back(mk_known('{0, 0, 16, 0, 0, 16, 16, 16}, OP_CLOSED, 0, 0, 0));
		rows.push_back(mk_known('{0, 0, 32, 0, 16, 0, 48, 0}, OP_OPEN, 1, 16, 0));
		rows.push_back(mk_known('{0, 0, 32, 0, 64, 0, 96, 0}, OP_CLOSED, 0, 0, 0));
		rows.push_back(mk('{0, 0, 32, 0, 32, 0, 64, 0}, OP_OPEN));
		rows.push_back(mk('{0, 0, 32, 0, 32, 0, 64, 0}, OP_CLOSED));
		rows.push_back(mk('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
			OP_CLOSED));
		rows.push_back(mk('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
			OP_OPEN));
		rows.push_back(mk('{-32768, 0, 32767, 1, 32767, -32768, 32766, 32767}, OP_CLOSED));
		rows.push_back(mk('{32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768},
			OP_OPEN));
		rows.push_back(mk('{-1, -1, -1, -1, -1, -1, 5, 5}, OP_CLOSED));
		rows.push_back(mk('{3, 3, 3, 3, -5, -5, 9, 9}, OP_OPEN));
		rows.push_back(mk('{0, 0, 1, 0, 0, 0, 0, 1}, OP_CLOSED));
		foreach (rows[i]) send(rows[i]);
		@(negedge clk);
		seg_in.valid <= 1'b0;
		drain();

		tols = '{20'hfffff, 20'd1, 20'd300, 20'd0};
		for (int ph = 0; ph < 4; ph++) begin
			write_tolerance(tols[ph] == 20'd300 ? 20'($urandom_range(1, 5000)) : tols[ph]);
			for (int k = 0; k < 12; k++) send(rows[k]);
			n = 0;
			while (n < 340) begin
				if (ph == 1 && n == 100) begin
					fork
						begin
							hold_long = 1;
							repeat (4 * LATENCY) @(posedge clk);
							hold_long = 0;
						end
					join_none
				end
				send(random_pair());
				n++;
				idle_gap();
			end
			@(negedge clk);
			seg_in.valid <= 1'b0;
			drain();
		end

		if (errors == 0 && pending.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule

/* filelist.f */
rtl/sit_pkg.sv
rtl/sit_if.sv
rtl/sit_div_pipe.sv
rtl/segment_intersection_test.sv
sim/testbench.sv
